// ----- design/servo_drive_enable_sequencer_top_assert.svh -----
// Assertion macros used by the back end of the servo drive enable sequencer RTL.
`ifndef SERVO_DRIVE_ENABLE_SEQUENCER_TOP_ASSERT_SVH
`define SERVO_DRIVE_ENABLE_SEQUENCER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDS_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// The consequent must hold in the cycle after the antecedent.
`define SDS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`endif

// ----- design/sds_pkg.sv -----
// Package with the types and constants of the servo drive enable sequencer.
`default_nettype none

package sds_pkg;

  // Depth of the queue between front and back and of the result queue.
  localparam int SDS_QUEUE_DEPTH = 2;

  // Register indexes of the configuration port.
  localparam logic REG_ENABLE_TIMEOUT = 1'b0;
  localparam logic REG_RAMP_STEP      = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [15:0] ENABLE_TIMEOUT_RESET = 16'd200;
  localparam logic [23:0] RAMP_STEP_RESET      = 24'd1000;

  // Link control mode codes.
  localparam logic [1:0] MODE_POSITION = 2'd0;
  localparam logic [1:0] MODE_FORCE    = 2'd2;

  // Drive operation mode codes.
  localparam logic [3:0] OPMODE_POSITION = 4'h8;
  localparam logic [3:0] OPMODE_VELOCITY = 4'h9;
  localparam logic [3:0] OPMODE_TORQUE   = 4'hA;

  // Control word bits.
  localparam logic [7:0] CW_SWITCH_ON    = 8'h01;
  localparam logic [7:0] CW_VOLTAGE      = 8'h02;
  localparam logic [7:0] CW_NO_QUICKSTOP = 8'h04;
  localparam logic [7:0] CW_OPERATION    = 8'h08;
  localparam logic [7:0] CW_FAULT_RESET  = 8'h80;

  // Status word and feedback status bit positions.
  localparam int SW_READY_BIT     = 0;
  localparam int SW_SWITCHED_BIT  = 1;
  localparam int SW_OP_EN_BIT     = 2;
  localparam int SW_FAULT_BIT     = 3;
  localparam int SW_SOD_BIT       = 6;
  localparam int FB_NO_MOTOR_BIT  = 13;

  // Device state codes.
  typedef enum logic [2:0] {
    DS_NOT_READY = 3'd0,
    DS_DISABLING = 3'd1,
    DS_ENABLING  = 3'd2,
    DS_ENABLED   = 3'd3,
    DS_READY     = 3'd4
  } sds_dstate_t;

  // Classified input word handed from front to back.
  typedef struct packed {
    logic               rtso;
    logic               switched_on;
    logic               op_en;
    logic               fault;
    logic               sod;
    logic               motor;
    logic               en_req;
    logic               dis_req;
    logic               enc_req;
    logic               linked;
    logic [3:0]         opmode;
    logic signed [31:0] manual_tgt;
    logic signed [31:0] ext_tgt;
  } sds_item_t;

  // Result word handed from back to the result queue.
  typedef struct packed {
    logic [7:0]         control_word;
    logic [3:0]         operation_mode;
    logic signed [31:0] target_velocity;
    logic [2:0]         device_state;
    logic               motor_present;
    logic               fault_raised;
    logic               encoder_reset_start;
  } sds_result_t;

endpackage

`default_nettype wire

// ----- design/sds_fifo.sv -----
// Small first-in first-out queue of words with full and empty flags.
`default_nettype none

module sds_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/sds_front.sv -----
// Front end: accepts input words and decodes them into classified items.
`default_nettype none

module sds_front import sds_pkg::*; (
  input  wire logic               push,
  input  wire logic        [15:0] status_word,
  input  wire logic        [15:0] feedback_status,
  input  wire logic               enable_request,
  input  wire logic               disable_request,
  input  wire logic               encoder_reset_request,
  input  wire logic               link_connected,
  input  wire logic        [1:0]  control_mode,
  input  wire logic signed [31:0] manual_velocity_target,
  input  wire logic signed [31:0] external_velocity_target,
  input  wire logic               queue_full,
  output logic                    queue_push,
  output sds_item_t               item
);

  logic [3:0] opmode;

  // Operation mode: manual runs velocity; a linked controller picks the mode,
  // with the undefined codes falling back to velocity.
  always_comb begin
    opmode = OPMODE_VELOCITY;
    if (link_connected) begin
      case (control_mode)
        MODE_POSITION: opmode = OPMODE_POSITION;
        MODE_FORCE:    opmode = OPMODE_TORQUE;
        default:       opmode = OPMODE_VELOCITY;
      endcase
    end
  end

  // Status flag decode and packing of the word for the back end.
  always_comb begin
    item.rtso        = status_word[SW_READY_BIT];
    item.switched_on = status_word[SW_SWITCHED_BIT];
    item.op_en       = status_word[SW_OP_EN_BIT];
    item.fault       = status_word[SW_FAULT_BIT];
    item.sod         = status_word[SW_SOD_BIT];
    item.motor       = !feedback_status[FB_NO_MOTOR_BIT];
    item.en_req      = enable_request;
    item.dis_req     = disable_request;
    item.enc_req     = encoder_reset_request;
    item.linked      = link_connected;
    item.opmode      = opmode;
    item.manual_tgt  = manual_velocity_target;
    item.ext_tgt     = external_velocity_target;
  end

  assign queue_push = push && !queue_full;

endmodule

`default_nettype wire

// ----- design/sds_back.sv -----
// Back end: power state sequencing, control word and velocity ramp.
`default_nettype none

module sds_back import sds_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire sds_item_t   item,
  input  wire logic        item_valid,
  output logic             item_take,
  output sds_result_t      res,
  output logic             res_push,
  input  wire logic        res_full
);

  `include "servo_drive_enable_sequencer_top_assert.svh"

  // Configuration registers.
  logic [15:0] enable_timeout_cycles;
  logic [23:0] ramp_step;

  // Sequencer state.
  logic               enable_target;
  logic               waiting_enable;
  logic [15:0]        enable_wait_count;
  logic               previous_fault;
  logic               reset_pending;
  logic signed [31:0] velocity_profile;

  logic               enable_target_next;
  logic               waiting_enable_next;
  logic [15:0]        enable_wait_count_next;
  logic               reset_pending_next;
  logic signed [31:0] velocity_profile_next;

  logic               fire;
  sds_dstate_t        dstate;
  logic               enabled;
  logic               disable_now;
  logic               pending;
  logic               fault_reset;
  logic [7:0]         cw;

  // Ramp datapath.
  logic               ramp_up;
  logic               ramp_down;
  logic signed [33:0] ramp_delta;
  logic signed [33:0] ramp_sum;
  logic signed [33:0] ramp_tgt;
  logic               ramp_over;
  logic signed [31:0] ramp_value;

  assign fire      = item_valid && !res_full;
  assign item_take = fire;
  assign res_push  = fire;

  // Device state from this word's status and the enable target held so far.
  always_comb begin
    if (!item.motor) begin
      dstate = DS_NOT_READY;
    end else if (item.op_en && !enable_target) begin
      dstate = DS_DISABLING;
    end else if (!item.op_en && enable_target) begin
      dstate = DS_ENABLING;
    end else if (item.op_en) begin
      dstate = DS_ENABLED;
    end else begin
      dstate = DS_READY;
    end
  end
  assign enabled = (dstate == DS_ENABLED);

  // Encoder reset disables the drive first and starts once it is not enabled.
  assign disable_now        = item.dis_req || item.enc_req;
  assign pending            = reset_pending || item.enc_req;
  assign reset_pending_next = pending && enabled;
  assign fault_reset        = item.en_req && item.fault;

  // Enable request handling with fault check and a timeout counted in processed words.
  always_comb begin
    waiting_enable_next    = waiting_enable || item.en_req;
    enable_wait_count_next = item.en_req ? '0 : enable_wait_count;
    enable_target_next     = enable_target;
    if (disable_now) begin
      waiting_enable_next = 1'b0;
      enable_target_next  = 1'b0;
    end
    if (waiting_enable_next) begin
      enable_target_next = !item.fault;
      if (!item.en_req && (enable_wait_count_next >= enable_timeout_cycles)) begin
        waiting_enable_next = 1'b0;
        enable_target_next  = 1'b0;
      end else begin
        if (!item.en_req) begin
          enable_wait_count_next = enable_wait_count_next + 1'b1;
        end
        if (item.op_en) begin
          waiting_enable_next = 1'b0;
        end
      end
    end else if (enable_target_next && !item.op_en) begin
      enable_target_next = 1'b0;
    end
  end

  // Control word steps through the power states.
  always_comb begin
    cw = CW_NO_QUICKSTOP;
    if (enable_target_next && item.switched_on) begin
      cw = cw | CW_SWITCH_ON | CW_VOLTAGE | CW_OPERATION;
    end else if (enable_target_next && item.rtso) begin
      cw = cw | CW_SWITCH_ON | CW_VOLTAGE;
    end else if (enable_target_next && item.sod) begin
      cw = cw | CW_VOLTAGE;
    end
    if (fault_reset) begin
      cw = cw | CW_FAULT_RESET;
    end
  end

  // Manual ramp: one signed add and a clamp so the target is never passed.
  assign ramp_up    = velocity_profile < item.manual_tgt;
  assign ramp_down  = velocity_profile > item.manual_tgt;
  assign ramp_delta = ramp_up ? $signed({10'd0, ramp_step})
                              : -$signed({10'd0, ramp_step});
  assign ramp_sum   = 34'(velocity_profile) + ramp_delta;
  assign ramp_tgt   = 34'(item.manual_tgt);
  assign ramp_over  = ramp_up ? (ramp_sum > ramp_tgt) : (ramp_sum < ramp_tgt);

  always_comb begin
    if (!ramp_up && !ramp_down) begin
      ramp_value = velocity_profile;
    end else if (ramp_over) begin
      ramp_value = item.manual_tgt;
    end else begin
      ramp_value = ramp_sum[31:0];
    end
    if (item.linked || !enabled) begin
      velocity_profile_next = '0;
    end else begin
      velocity_profile_next = ramp_value;
    end
  end

  // Result word.
  always_comb begin
    res.control_word        = cw;
    res.operation_mode      = item.opmode;
    res.target_velocity     = item.linked ? item.ext_tgt : velocity_profile_next;
    res.device_state        = dstate;
    res.motor_present       = item.motor;
    res.fault_raised        = item.fault && !previous_fault;
    res.encoder_reset_start = pending && !enabled;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_timeout_cycles <= ENABLE_TIMEOUT_RESET;
      ramp_step             <= RAMP_STEP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ENABLE_TIMEOUT: enable_timeout_cycles <= cfg_data[15:0];
        REG_RAMP_STEP:      ramp_step             <= cfg_data;
        default:            ramp_step             <= ramp_step;
      endcase
    end
  end

  // Sequencer state update, once per processed word.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_target     <= 1'b0;
      waiting_enable    <= 1'b0;
      enable_wait_count <= '0;
      previous_fault    <= 1'b0;
      reset_pending     <= 1'b0;
      velocity_profile  <= '0;
    end else if (fire) begin
      enable_target     <= enable_target_next;
      waiting_enable    <= waiting_enable_next;
      enable_wait_count <= enable_wait_count_next;
      previous_fault    <= item.fault;
      reset_pending     <= reset_pending_next;
      velocity_profile  <= velocity_profile_next;
    end
  end

  // The encoder offset write never starts while the drive is enabled.
  `SDS_ASSERT_SAME(a_enc_start_not_enabled, clk, rst, fire && res.encoder_reset_start, res.device_state != DS_ENABLED)
  // Fault reset is only requested while the drive reports a fault.
  `SDS_ASSERT_SAME(a_fault_reset_on_fault, clk, rst, fire && res.control_word[7], item.fault && item.en_req)
  // A disable or encoder reset drops the enable target right away.
  `SDS_ASSERT_NEXT(a_disable_drops_target, clk, rst, fire && disable_now, !enable_target && !waiting_enable)
  // The manual profile is held at zero while linked.
  `SDS_ASSERT_NEXT(a_linked_profile_zero, clk, rst, fire && item.linked, velocity_profile == '0)

endmodule

`default_nettype wire

// ----- design/servo_drive_enable_sequencer_top.sv -----
// Top level of the servo drive enable sequencer.
// Takes one word per process cycle and returns one result word for each
// accepted one: the drive control word, operation mode, velocity command,
// device state and event pulses. A word can be pushed on every clock while the
// queue is not full; the front decodes it into a queue of QUEUE_DEPTH entries,
// the back updates the sequencer state once per word, and the result lands in
// a result queue of the same depth, which registers it for popping. The rate
// is one word per clock while the result queue is not full, set by the state
// update of the back. The user must write the configuration registers only
// while no words are in flight; the block does not enforce this.
`default_nettype none

module servo_drive_enable_sequencer_top import sds_pkg::*; #(
  parameter int QUEUE_DEPTH = SDS_QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic        [23:0] cfg_data,
  input  wire logic               push,
  output logic                    full,
  input  wire logic        [15:0] status_word,
  input  wire logic        [15:0] feedback_status,
  input  wire logic               enable_request,
  input  wire logic               disable_request,
  input  wire logic               encoder_reset_request,
  input  wire logic               link_connected,
  input  wire logic        [1:0]  control_mode,
  input  wire logic signed [31:0] manual_velocity_target,
  input  wire logic signed [31:0] external_velocity_target,
  output logic                    empty,
  input  wire logic               pop,
  output logic             [7:0]  control_word,
  output logic             [3:0]  operation_mode,
  output logic signed      [31:0] target_velocity,
  output logic             [2:0]  device_state,
  output logic                    motor_present,
  output logic                    fault_raised,
  output logic                    encoder_reset_start
);

  localparam int ITEM_W = $bits(sds_item_t);
  localparam int RES_W  = $bits(sds_result_t);

  sds_item_t         front_item;
  logic              front_push;
  logic [ITEM_W-1:0] mid_rdata;
  logic              mid_empty;
  logic              back_take;
  sds_result_t       back_res;
  logic              back_push;
  logic              res_full;
  logic [RES_W-1:0]  res_rdata;
  sds_result_t       res_word;

  // Input decode.
  sds_front u_front (
    .push                     (push),
    .status_word              (status_word),
    .feedback_status          (feedback_status),
    .enable_request           (enable_request),
    .disable_request          (disable_request),
    .encoder_reset_request    (encoder_reset_request),
    .link_connected           (link_connected),
    .control_mode             (control_mode),
    .manual_velocity_target   (manual_velocity_target),
    .external_velocity_target (external_velocity_target),
    .queue_full               (full),
    .queue_push               (front_push),
    .item                     (front_item)
  );

  // Queue between front and back.
  sds_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .wdata (front_item),
    .full  (full),
    .pop   (back_take),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  // Sequencer.
  sds_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item       (sds_item_t'(mid_rdata)),
    .item_valid (!mid_empty),
    .item_take  (back_take),
    .res        (back_res),
    .res_push   (back_push),
    .res_full   (res_full)
  );

  // Result queue.
  sds_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (back_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  // Result word onto the ports.
  assign res_word            = sds_result_t'(res_rdata);
  assign control_word        = res_word.control_word;
  assign operation_mode      = res_word.operation_mode;
  assign target_velocity     = res_word.target_velocity;
  assign device_state        = res_word.device_state;
  assign motor_present       = res_word.motor_present;
  assign fault_raised        = res_word.fault_raised;
  assign encoder_reset_start = res_word.encoder_reset_start;

endmodule

`default_nettype wire
